### rtl/ntscan_pkg.sv
package ntscan_pkg;

    localparam int MAX_TOKEN_LEN_DEF = 255;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] KIND_PLUS    = 3'd0;
    localparam logic [2:0] KIND_MINUS   = 3'd1;
    localparam logic [2:0] KIND_NUMBER  = 3'd2;
    localparam logic [2:0] KIND_EOS     = 3'd3;
    localparam logic [2:0] KIND_INVALID = 3'd4;

    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_INT      = 8'b0000_0010,
        PH_INT_DOT  = 8'b0000_0100,
        PH_FRAC     = 8'b0000_1000,
        PH_LEAD_DOT = 8'b0001_0000,
        PH_EXP_MARK = 8'b0010_0000,
        PH_EXP_SIGN = 8'b0100_0000,
        PH_EXP_DIG  = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] length;
        logic       malformed;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0]       count;
        result_t [1:0]    res;
    } push_t;

endpackage

### rtl/numeric_token_scanner.sv
// Results enter the queue when their word is accepted; m_valid follows the registered entry count.
// Throughput: one word per cycle while s_ready is high; a word that yields two results writes both
// into the four-entry result queue together, and its single read port offers them one at a time.
// Input ready is high while the queue holds two results or fewer.
// Synchronous active-low reset returns the scanner to idle with zero length and empties the queue.
module numeric_token_scanner #(
    parameter int MAX_TOKEN_LEN = ntscan_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_byte,
    input  logic       s_end_of_stream,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_token_kind,
    output logic [7:0] m_token_length,
    output logic       m_malformed,
    output logic       m_last
);

    ntscan_pkg::push_t   push;
    ntscan_pkg::result_t res;
    logic                accept;

    assign accept = s_valid && s_ready;

    ntscan_fsm #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
    ) u_fsm (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .char_byte     (s_char_byte),
        .end_of_stream (s_end_of_stream),
        .push          (push)
    );

    ntscan_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (res)
    );

    assign m_token_kind   = res.kind;
    assign m_token_length = res.length;
    assign m_malformed    = res.malformed;
    assign m_last         = res.last;

endmodule

### rtl/ntscan_fsm.sv
module ntscan_fsm #(
    parameter int MAX_TOKEN_LEN = ntscan_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        char_byte,
    input  logic              end_of_stream,
    output ntscan_pkg::push_t push
);

    localparam logic [7:0] LEN_CAP = (MAX_TOKEN_LEN < 255) ? 8'(MAX_TOKEN_LEN) : 8'd255;

    ntscan_pkg::phase_t phase_reg, phase_next, nx;
    logic [7:0]         len_reg, len_next;

    logic                is_digit, is_exp, is_space;
    logic                tok_valid, num_valid, bad;
    ntscan_pkg::result_t tok, num;
    ntscan_pkg::push_t   p;

    always_comb begin
        is_digit = (char_byte >= ntscan_pkg::CH_ZERO) && (char_byte <= ntscan_pkg::CH_NINE);
        is_exp   = (char_byte == ntscan_pkg::CH_E_LO) || (char_byte == ntscan_pkg::CH_E_UP);
        is_space = (char_byte == ntscan_pkg::CH_SPACE) || (char_byte == ntscan_pkg::CH_TAB) ||
                   (char_byte == ntscan_pkg::CH_LF) || (char_byte == ntscan_pkg::CH_CR);

        nx = ntscan_pkg::PH_IDLE;
        unique case (phase_reg)
            ntscan_pkg::PH_INT: begin
                if (is_digit) nx = ntscan_pkg::PH_INT;
                else if (char_byte == ntscan_pkg::CH_DOT) nx = ntscan_pkg::PH_INT_DOT;
                else if (is_exp) nx = ntscan_pkg::PH_EXP_MARK;
            end
            ntscan_pkg::PH_INT_DOT, ntscan_pkg::PH_FRAC: begin
                if (is_digit) nx = ntscan_pkg::PH_FRAC;
                else if (is_exp) nx = ntscan_pkg::PH_EXP_MARK;
            end
            ntscan_pkg::PH_LEAD_DOT: begin
                if (is_digit) nx = ntscan_pkg::PH_FRAC;
            end
            ntscan_pkg::PH_EXP_MARK: begin
                if (is_digit) nx = ntscan_pkg::PH_EXP_DIG;
                else if ((char_byte == ntscan_pkg::CH_PLUS) ||
                         (char_byte == ntscan_pkg::CH_MINUS)) nx = ntscan_pkg::PH_EXP_SIGN;
            end
            ntscan_pkg::PH_EXP_SIGN, ntscan_pkg::PH_EXP_DIG: begin
                if (is_digit) nx = ntscan_pkg::PH_EXP_DIG;
            end
            default: nx = ntscan_pkg::PH_IDLE;
        endcase
        if (end_of_stream) nx = ntscan_pkg::PH_IDLE;

        bad = (phase_reg == ntscan_pkg::PH_LEAD_DOT) || (phase_reg == ntscan_pkg::PH_EXP_MARK) ||
              (phase_reg == ntscan_pkg::PH_EXP_SIGN);
        num = '{kind: ntscan_pkg::KIND_NUMBER, length: len_reg, malformed: bad, last: 1'b0};

        phase_next = phase_reg;
        len_next   = len_reg;
        tok_valid  = 1'b0;
        num_valid  = 1'b0;
        tok        = '{kind: ntscan_pkg::KIND_INVALID, length: 8'd1, malformed: 1'b0,
                       last: 1'b0};
        p          = '0;

        if ((phase_reg != ntscan_pkg::PH_IDLE) && (nx != ntscan_pkg::PH_IDLE)) begin
            phase_next = nx;
            if (len_reg < LEN_CAP) len_next = len_reg + 8'd1;
        end else begin
            num_valid  = (phase_reg != ntscan_pkg::PH_IDLE);
            phase_next = ntscan_pkg::PH_IDLE;
            len_next   = 8'd0;
            if (end_of_stream) begin
                tok_valid  = 1'b1;
                tok.kind   = ntscan_pkg::KIND_EOS;
                tok.length = 8'd0;
            end else if (is_space) begin
                tok_valid = 1'b0;
            end else if (char_byte == ntscan_pkg::CH_PLUS) begin
                tok_valid = 1'b1;
                tok.kind  = ntscan_pkg::KIND_PLUS;
            end else if (char_byte == ntscan_pkg::CH_MINUS) begin
                tok_valid = 1'b1;
                tok.kind  = ntscan_pkg::KIND_MINUS;
            end else if (is_digit) begin
                phase_next = ntscan_pkg::PH_INT;
                len_next   = 8'd1;
            end else if (char_byte == ntscan_pkg::CH_DOT) begin
                phase_next = ntscan_pkg::PH_LEAD_DOT;
                len_next   = 8'd1;
            end else begin
                tok_valid = 1'b1;
            end

            if (num_valid) begin
                p.res[0] = num;
                if (tok_valid) begin
                    p.res[1]      = tok;
                    p.res[1].last = 1'b1;
                    p.count       = 2'd2;
                end else begin
                    p.res[0].last = 1'b1;
                    p.count       = 2'd1;
                end
            end else if (tok_valid) begin
                p.res[0]      = tok;
                p.res[0].last = 1'b1;
                p.count       = 2'd1;
            end
        end

        push = p;
        if (!accept) push.count = 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ntscan_pkg::PH_IDLE;
            len_reg   <= 8'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
        end
    end

endmodule

### rtl/ntscan_outq.sv
module ntscan_outq (
    input  logic                aclk,
    input  logic                aresetn,
    input  ntscan_pkg::push_t   push,
    output logic                room,
    output logic                m_valid,
    input  logic                m_ready,
    output ntscan_pkg::result_t m_res
);

    ntscan_pkg::result_t mem [ntscan_pkg::QUEUE_DEPTH];

    logic [ntscan_pkg::PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [ntscan_pkg::CNT_W-1:0] count_reg, count_next;
    logic                         pop;

    assign m_valid = (count_reg != '0);
    assign m_res   = mem[rd_reg];
    assign pop     = m_valid && m_ready;
    assign room    = (count_reg <= ntscan_pkg::CNT_W'(ntscan_pkg::QUEUE_DEPTH - 2));

    always_comb begin
        wr_next    = wr_reg + ntscan_pkg::PTR_W'(push.count);
        rd_next    = rd_reg + ntscan_pkg::PTR_W'(pop);
        count_next = count_reg + ntscan_pkg::CNT_W'(push.count) - ntscan_pkg::CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) mem[wr_reg] <= push.res[0];
        if (push.count == 2'd2) mem[wr_reg + ntscan_pkg::PTR_W'(1)] <= push.res[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule
